// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MHPQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/mhpq_pkg.sv =====
// Package for the min-heap priority queue: codes, defaults and control types.
package mhpq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int VAL_W         = 32;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } mhpq_state_t;

  typedef struct packed {
    logic load;
    logic ins_begin;
    logic rem_begin;
    logic clr;
    logic set_err_empty;
    logic set_err_full;
    logic last_cap;
    logic up_rd;
    logic up_move;
    logic dn_rd;
    logic dn_move;
    logic put_key;
    logic finish;
  } mhpq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       one;
    logic       pos_zero;
    logic       up_lt;
    logic       no_left;
    logic       dn_lt;
  } mhpq_stat_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module mhpq_ram #(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [W-1:0]  rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== hdl/mhpq_ctrl.sv =====
// Controller state machine for the min-heap priority queue.
module mhpq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  input  mhpq_pkg::mhpq_stat_t stat,
  output mhpq_pkg::mhpq_cmd_t  cmd
);

  mhpq_pkg::mhpq_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      mhpq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = mhpq_pkg::ST_DECODE;
        end
      end
      mhpq_pkg::ST_DECODE: begin
        state_nxt = mhpq_pkg::ST_FINISH;
        case (stat.op)
          mhpq_pkg::FN_INSERT: begin
            if (stat.full) begin
              cmd.set_err_full = 1'b1;
            end else begin
              cmd.ins_begin = 1'b1;
              state_nxt     = mhpq_pkg::ST_UP_RD;
            end
          end
          mhpq_pkg::FN_REMOVE: begin
            if (stat.empty) begin
              cmd.set_err_empty = 1'b1;
            end else begin
              cmd.rem_begin = 1'b1;
              if (!stat.one) begin
                state_nxt = mhpq_pkg::ST_DN_LAST;
              end
            end
          end
          mhpq_pkg::FN_CLEAR: begin
            cmd.clr = 1'b1;
          end
          default: begin
            state_nxt = mhpq_pkg::ST_FINISH;
          end
        endcase
      end
      mhpq_pkg::ST_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.put_key = 1'b1;
          state_nxt   = mhpq_pkg::ST_FINISH;
        end else begin
          cmd.up_rd = 1'b1;
          state_nxt = mhpq_pkg::ST_UP_CMP;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        if (stat.up_lt) begin
          cmd.up_move = 1'b1;
          state_nxt   = mhpq_pkg::ST_UP_RD;
        end else begin
          cmd.put_key = 1'b1;
          state_nxt   = mhpq_pkg::ST_FINISH;
        end
      end
      mhpq_pkg::ST_DN_LAST: begin
        cmd.last_cap = 1'b1;
        state_nxt    = mhpq_pkg::ST_DN_RD;
      end
      mhpq_pkg::ST_DN_RD: begin
        if (stat.no_left) begin
          cmd.put_key = 1'b1;
          state_nxt   = mhpq_pkg::ST_FINISH;
        end else begin
          cmd.dn_rd = 1'b1;
          state_nxt = mhpq_pkg::ST_DN_CMP;
        end
      end
      mhpq_pkg::ST_DN_CMP: begin
        if (stat.dn_lt) begin
          cmd.dn_move = 1'b1;
          state_nxt   = mhpq_pkg::ST_DN_RD;
        end else begin
          cmd.put_key = 1'b1;
          state_nxt   = mhpq_pkg::ST_FINISH;
        end
      end
      mhpq_pkg::ST_FINISH: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = mhpq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != mhpq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/mhpq_dp.sv =====
// Datapath for the min-heap priority queue: key store, sift registers, result registers.
module mhpq_dp #(
  parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_func,
  input  logic signed [mhpq_pkg::VAL_W-1:0] in_value,
  input  mhpq_pkg::mhpq_cmd_t               cmd,
  output mhpq_pkg::mhpq_stat_t              stat,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_removed_value,
  output logic                              out_removed_valid,
  output logic [1:0]                        out_error_code,
  output logic [CW-1:0]                     out_entry_count_out,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_front_value,
  output logic                              out_front_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW + 2;
  localparam int VW = mhpq_pkg::VAL_W;

  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [AW-1:0]        pos_r;
  logic [CW-1:0]        cnt_r;
  logic [KEY_WIDTH-1:0] front_r;
  logic [KEY_WIDTH-1:0] rem_val_r;
  logic                 rem_vld_r;
  logic [1:0]           err_r;

  logic [IW-1:0]        pos_x, l_idx, r_idx, cnt_x;
  logic [AW-1:0]        par_idx, child_idx;
  logic                 has_l, has_r, r_lt_l;
  logic [KEY_WIDTH-1:0] rd_a, rd_b, child_v;
  logic                 we;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr_a;

  function automatic logic [VW-1:0] key_ext(input logic [KEY_WIDTH-1:0] k);
    key_ext = VW'($signed(k));
  endfunction

  assign pos_x     = IW'(pos_r);
  assign l_idx     = (pos_x << 1) + IW'(1);
  assign r_idx     = l_idx + IW'(1);
  assign cnt_x     = IW'(cnt_r);
  assign par_idx   = (pos_r - AW'(1)) >> 1;
  assign has_l     = (l_idx < cnt_x);
  assign has_r     = (r_idx < cnt_x);
  assign r_lt_l    = has_r && ($signed(rd_b) < $signed(rd_a));
  assign child_v   = r_lt_l ? rd_b : rd_a;
  assign child_idx = r_lt_l ? r_idx[AW-1:0] : l_idx[AW-1:0];

  always_comb begin
    if (cmd.rem_begin) begin
      raddr_a = AW'(cnt_r - CW'(1));
    end else if (cmd.up_rd) begin
      raddr_a = par_idx;
    end else begin
      raddr_a = l_idx[AW-1:0];
    end
  end

  assign we    = cmd.put_key | cmd.up_move | cmd.dn_move;
  assign wdata = cmd.put_key ? key_r : (cmd.up_move ? rd_a : child_v);

  mhpq_ram #(
    .W (KEY_WIDTH),
    .D (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (r_idx[AW-1:0]),
    .rdata_b (rd_b)
  );

  always_comb begin
    stat.op       = op_r;
    stat.full     = (cnt_r == CW'(DEPTH));
    stat.empty    = (cnt_r == '0);
    stat.one      = (cnt_r == CW'(1));
    stat.pos_zero = (pos_r == '0);
    stat.up_lt    = ($signed(key_r) < $signed(rd_a));
    stat.no_left  = !has_l;
    stat.dn_lt    = ($signed(child_v) < $signed(key_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ins_begin) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.rem_begin) begin
      cnt_r <= cnt_r - CW'(1);
    end else if (cmd.clr) begin
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_func;
      key_r     <= KEY_WIDTH'($unsigned(in_value));
      err_r     <= mhpq_pkg::ERR_OK;
      rem_vld_r <= 1'b0;
    end
    if (cmd.ins_begin) begin
      pos_r <= AW'(cnt_r);
    end
    if (cmd.rem_begin) begin
      rem_val_r <= front_r;
      rem_vld_r <= 1'b1;
      pos_r     <= '0;
    end
    if (cmd.set_err_empty) begin
      err_r <= mhpq_pkg::ERR_EMPTY;
    end
    if (cmd.set_err_full) begin
      err_r <= mhpq_pkg::ERR_FULL;
    end
    if (cmd.last_cap) begin
      key_r <= rd_a;
    end
    if (cmd.up_move) begin
      pos_r <= par_idx;
    end
    if (cmd.dn_move) begin
      pos_r <= child_idx;
    end
    if (we && (pos_r == '0)) begin
      front_r <= wdata;
    end
    if (cmd.finish) begin
      out_removed_value   <= rem_vld_r ? key_ext(rem_val_r) : '0;
      out_removed_valid   <= rem_vld_r;
      out_error_code      <= err_r;
      out_entry_count_out <= cnt_r;
      out_front_value     <= (cnt_r != '0) ? key_ext(front_r) : '0;
      out_front_valid     <= (cnt_r != '0);
    end
  end

endmodule

// ===== hdl/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue.
// Usage:
//   A request is taken at a rising edge with start high and busy low; in_func
//   selects insert (in_value is the key), remove-minimum or clear. busy stays
//   high until the request is finished; start while busy is ignored.
//   Each request gives one result: out_valid is high for exactly one cycle
//   with the out_ fields, and the receiver cannot hold it off.
// Sequencing: an accepted request is decoded and then finished. Clear, errors,
//   no-op and a remove that empties the heap go straight from decode to finish;
//   an insert climbs from the new last slot, and a remove first loads the last
//   key, then sinks from the root. Either walk ends by writing the key into its
//   slot, at the root or a leaf or where the compare stops it. Each heap level
//   costs one read of the key store and one compare-and-write step; the sift
//   loop sets the rate, one request at a time, and a new request is taken in
//   the cycle the result is shown.
// Reset: synchronous, active low; the heap becomes empty. Stored keys are not
//   cleared, the entry count alone marks which are live.
module min_heap_priority_queue #(
  parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [mhpq_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_removed_value,
  output logic                              out_removed_valid,
  output logic [1:0]                        out_error_code,
  output logic [CW-1:0]                     out_entry_count_out,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_front_value,
  output logic                              out_front_valid
);

  mhpq_pkg::mhpq_cmd_t  cmd;
  mhpq_pkg::mhpq_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  mhpq_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_func             (in_func),
    .in_value            (in_value),
    .cmd                 (cmd),
    .stat                (stat),
    .out_removed_value   (out_removed_value),
    .out_removed_valid   (out_removed_valid),
    .out_error_code      (out_error_code),
    .out_entry_count_out (out_entry_count_out),
    .out_front_value     (out_front_value),
    .out_front_valid     (out_front_valid)
  );

endmodule

// ===== hdl/mhpq_checker.sv =====
// Port-level checker for the min-heap priority queue, bound to the top level.
`include "assert_macros.svh"

module mhpq_checker #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input logic          out_removed_valid,
  input logic [1:0]    out_error_code,
  input logic [CW-1:0] out_entry_count_out,
  input logic          out_front_valid
);

  logic cnt_nz;
  logic rem_ok;

  assign cnt_nz = (out_entry_count_out != '0);
  assign rem_ok = (out_error_code == mhpq_pkg::ERR_OK) && (out_entry_count_out != CW'(DEPTH));

  // accepted request always starts work
  `MHPQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  // one strobe per request
  `MHPQ_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `MHPQ_NEVER(a_strobe_busy, out_valid && busy, "result shown while still busy")
  `MHPQ_ASSERT(a_front_count, out_valid |-> (out_front_valid == cnt_nz), "bad front_valid")
  `MHPQ_ASSERT(a_removed_ok, (out_valid && out_removed_valid) |-> rem_ok, "bad removed entry")

endmodule

bind min_heap_priority_queue mhpq_checker #(.DEPTH(DEPTH)) u_mhpq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_removed_valid   (out_removed_valid),
  .out_error_code      (out_error_code),
  .out_entry_count_out (out_entry_count_out),
  .out_front_valid     (out_front_valid)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the min-heap priority queue top level.
module tb;

  localparam int DEPTH = mhpq_pkg::DEPTH_DEF;
  localparam int VAL_W = mhpq_pkg::VAL_W;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] FN_NOP = 2'd3;

  typedef struct {
    logic signed [VAL_W-1:0] removed_value;
    logic                    removed_valid;
    logic [1:0]              error_code;
    logic [CW-1:0]           entry_count;
    logic signed [VAL_W-1:0] front_value;
    logic                    front_valid;
  } heap_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_func;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_removed_value;
  logic                    out_removed_valid;
  logic [1:0]              out_error_code;
  logic [CW-1:0]           out_entry_count_out;
  logic signed [VAL_W-1:0] out_front_value;
  logic                    out_front_valid;

  logic signed [VAL_W-1:0] heap_keys [DEPTH];
  int                      heap_count;
  heap_result_t            pending_results [$];
  int                      fail_count = 0;
  int                      stall_cycles = 0;
  bit                      idle_enable;

  min_heap_priority_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_removed_value   (out_removed_value),
    .out_removed_valid   (out_removed_valid),
    .out_error_code      (out_error_code),
    .out_entry_count_out (out_entry_count_out),
    .out_front_value     (out_front_value),
    .out_front_valid     (out_front_valid)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expected result of one request; updates the shadow heap.
  task automatic predict_request(input logic [1:0] func, input logic signed [VAL_W-1:0] key);
    heap_result_t r;
    int pos;
    int up;
    int best;
    int lc;
    int rc;
    logic signed [VAL_W-1:0] t;
    r = '{default: '0};
    case (func)
      mhpq_pkg::FN_INSERT: begin
        if (heap_count >= DEPTH) begin
          r.error_code = mhpq_pkg::ERR_FULL;
        end else begin
          heap_keys[heap_count] = key;
          pos = heap_count;
          heap_count++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_keys[pos] >= heap_keys[up]) break;
            t = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up] = t;
            pos = up;
          end
        end
      end
      mhpq_pkg::FN_REMOVE: begin
        if (heap_count == 0) begin
          r.error_code = mhpq_pkg::ERR_EMPTY;
        end else begin
          r.removed_value = heap_keys[0];
          r.removed_valid = 1'b1;
          heap_keys[0] = heap_keys[heap_count - 1];
          heap_count--;
          pos = 0;
          while (pos < heap_count) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < heap_count && heap_keys[lc] < heap_keys[best]) best = lc;
            if (rc < heap_count && heap_keys[rc] < heap_keys[best]) best = rc;
            if (best == pos) break;
            t = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = t;
            pos = best;
          end
        end
      end
      mhpq_pkg::FN_CLEAR: heap_count = 0;
      default: ;
    endcase
    r.entry_count = CW'(heap_count);
    if (heap_count > 0) begin
      r.front_value = heap_keys[0];
      r.front_valid = 1'b1;
    end
    pending_results.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] func, input logic signed [VAL_W-1:0] value);
    start = 1'b1;
    in_func = func;
    in_value = value;
    do @(posedge clk); while (busy);
    predict_request(func, value);
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 99) < 31) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic wait_results_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic check_field(input string field, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, got %h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("removed_value", exp_r.removed_value, out_removed_value);
        check_field("removed_valid", exp_r.removed_valid, out_removed_valid);
        check_field("error_code", exp_r.error_code, out_error_code);
        check_field("entry_count", exp_r.entry_count, out_entry_count_out);
        check_field("front_value", exp_r.front_value, out_front_value);
        check_field("front_valid", exp_r.front_valid, out_front_valid);
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(mhpq_pkg::FN_REMOVE, 32'sh5a5a5a5a);
    send_request(FN_NOP, 32'sh0);
    send_request(mhpq_pkg::FN_CLEAR, -32'sd1);
    send_request(mhpq_pkg::FN_INSERT, 32'sd0);
    send_request(mhpq_pkg::FN_INSERT, 32'sh7fffffff);
    send_request(mhpq_pkg::FN_INSERT, 32'sh80000000);
    send_request(mhpq_pkg::FN_INSERT, -32'sd1);
    send_request(mhpq_pkg::FN_INSERT, 32'sd1);
    send_request(mhpq_pkg::FN_INSERT, 32'sd1);
    send_request(mhpq_pkg::FN_INSERT, 32'sh80000000);
    send_request(FN_NOP, -32'sd1);
    repeat (4) send_request(mhpq_pkg::FN_REMOVE, -32'sd1);
    send_request(mhpq_pkg::FN_CLEAR, 32'sh0);
    send_request(mhpq_pkg::FN_REMOVE, 32'sh0);
    send_request(mhpq_pkg::FN_INSERT, 32'sh7fffffff);
    send_request(mhpq_pkg::FN_INSERT, 32'sh12345678);
    repeat (3) send_request(mhpq_pkg::FN_REMOVE, 32'sh0);
  endtask

  // Fill to capacity, overflow, then drain past empty.
  task automatic test_full_heap();
    repeat (DEPTH) begin
      send_request(mhpq_pkg::FN_INSERT, pick_key());
      maybe_idle();
    end
    send_request(mhpq_pkg::FN_INSERT, 32'sh7fffffff);
    send_request(mhpq_pkg::FN_INSERT, 32'sh80000000);
    send_request(FN_NOP, pick_key());
    repeat (DEPTH + 1) begin
      send_request(mhpq_pkg::FN_REMOVE, $signed($urandom));
      maybe_idle();
    end
  endtask

  task automatic test_drain_pause();
    repeat (8) send_request(mhpq_pkg::FN_INSERT, pick_key());
    wait_results_drained();
    repeat (3) send_request(mhpq_pkg::FN_REMOVE, pick_key());
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    int n;
    int insert_pct;
    int mode_left;
    int roll;
    insert_pct = 75;
    mode_left = 0;
    for (n = 0; n < 320; n++) begin
      idle_enable = !(n >= 100 && n < 180);
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 90);
        insert_pct = (insert_pct == 75) ? 25 : 75;
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2)
        send_request(mhpq_pkg::FN_CLEAR, $signed($urandom));
      else if (roll < 4)
        send_request(FN_NOP, $signed($urandom));
      else if ($urandom_range(0, 99) < insert_pct)
        send_request(mhpq_pkg::FN_INSERT, pick_key());
      else
        send_request(mhpq_pkg::FN_REMOVE, $signed($urandom));
      if (n % 100 == 99) wait_results_drained();
      else maybe_idle();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = mhpq_pkg::FN_INSERT;
    in_value = '0;
    heap_count = 0;
    idle_enable = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_full_heap();
    test_drain_pause();
    test_random_mix();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
